// ===== hw/rtl/nfha_pkg.sv =====
package nfha_pkg;

   localparam int REQ_BYTES_W  = 16;
   localparam int USER_ADDR_W  = 16;
   localparam int STATUS_W     = 2;
   localparam int HEAP_START_W = 15;
   localparam int HEAP_END_W   = 16;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 16;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_HEAP_START = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAP_END   = 1'b1;

   localparam logic [STATUS_W-1:0] STAT_ALLOCATED = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NO_SPACE  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FREED     = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_IGNORED   = 2'd3;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP_LAST,
      ST_READ_CUR,
      ST_CHECK_CUR,
      ST_MERGE_READ,
      ST_MERGE_CHECK,
      ST_EVAL,
      ST_SPLIT_HEAD,
      ST_FREE_READ,
      ST_FREE_CHECK
   } nfha_state_type;

endpackage

// ===== hw/rtl/nfha_req_if.sv =====
interface nfha_req_if;
   import nfha_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   command;
   logic [REQ_BYTES_W-1:0] request_bytes;
   logic [USER_ADDR_W-1:0] release_address;

   modport source (output valid, command, request_bytes, release_address, input ready);
   modport sink   (input valid, command, request_bytes, release_address, output ready);
endinterface

// ===== hw/rtl/nfha_rsp_if.sv =====
interface nfha_rsp_if;
   import nfha_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [USER_ADDR_W-1:0] user_address;
   logic [STATUS_W-1:0]    status;

   modport source (output valid, user_address, status, input ready);
   modport sink   (input valid, user_address, status, output ready);
endinterface

// ===== hw/rtl/next_fit_heap_allocator.sv =====
// Channel | Dir | Payload                                  | Transfer
// req_ch  | in  | command, request_bytes, release_address  | valid & ready
// rsp_ch  | out | user_address, status                     | valid & ready
// csr_*   | in  | csr_index, csr_write_data                | csr_write_enable
//
// Reset starts a clearing pass over every header word, no transaction taken meanwhile.
// Allocate: walks headers from the rover, merging each free block with the free
// ones after it before the fit test, and splits off a large remainder; the first
// allocate builds the heap. Free: marks free and merges; bad or double frees ignored.
// req_ch.ready is high only in idle with the response register empty; a
// stalled response holds until taken.
module next_fit_heap_allocator #(
   parameter int HEAP_WORDS        = 4096,
   parameter int MIN_PAYLOAD_BYTES = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   nfha_req_if.sink                        req_ch,
   nfha_rsp_if.source                      rsp_ch,
   input  logic                            csr_write_enable,
   input  logic [nfha_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nfha_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import nfha_pkg::*;

   localparam int IW = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1;
   localparam int CW = IW + 1;
   // byte-domain width: covers request sizes and the whole region
   localparam int BW = (IW + 4 > 18) ? IW + 4 : 18;
   localparam logic [CW-1:0] HW_CNT     = CW'(HEAP_WORDS);
   localparam logic [IW-1:0] LAST_WORD  = IW'(HEAP_WORDS - 1);
   localparam logic [BW-1:0] HEAP_BYTES = BW'(HEAP_WORDS * 8);
   localparam logic [BW-1:0] SETUP_MIN  = BW'(16 + MIN_PAYLOAD_BYTES);
   localparam logic [BW-1:0] SPLIT_MIN  = BW'(8 + MIN_PAYLOAD_BYTES);
   localparam logic [BW-1:0] ALIGN_MASK = ~BW'(7);

   // config
   logic [HEAP_START_W-1:0] heap_start_ff;
   logic [HEAP_END_W-1:0]   heap_end_ff;

   nfha_state_type state_ff, state_in;

   logic          cmd_ff, cmd_in;
   logic [BW-1:0] want_ff, want_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [IW-1:0] cur_next_ff, cur_next_in;
   logic [IW-1:0] nb_ff, nb_in;
   logic [IW-1:0] start_ff, start_in;
   logic [IW-1:0] rover_ff, rover_in;
   logic [IW-1:0] first_ff, first_in;
   logic [IW-1:0] split_ff, split_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic [CW-1:0] step_ff, step_in;
   logic [CW-1:0] merge_ff, merge_in;
   logic          heap_ready_ff, heap_ready_in;

   logic                   rsp_valid_ff;
   logic [USER_ADDR_W-1:0] rsp_addr_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;

   logic                   done;
   logic [USER_ADDR_W-1:0] done_addr;
   logic [STATUS_W-1:0]    done_status;

   logic          mem_we;
   logic [IW-1:0] mem_addr;
   logic [IW-1:0] mem_wnext;
   logic          mem_wfree;
   logic [IW-1:0] rd_next;
   logic          rd_free;

   nfha_hdr_ram #(.DEPTH(HEAP_WORDS), .AW(IW)) u_hdr_ram (
      .clock   (clock),
      .we      (mem_we),
      .addr    (mem_addr),
      .wr_next (mem_wnext),
      .wr_free (mem_wfree),
      .rd_next (rd_next),
      .rd_free (rd_free)
   );

   logic req_fire;
   assign req_ch.ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_fire     = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.user_address = rsp_addr_ff;
   assign rsp_ch.status       = rsp_status_ff;

   // ---- first-allocate setup: align start up, clamp and align end down
   logic [BW-1:0] start_b, end_b, end_clamp;
   logic          too_small;
   logic [IW-1:0] setup_first, setup_last;
   always_comb begin
      start_b     = (BW'(heap_start_ff) + BW'(7)) & ALIGN_MASK;
      end_clamp   = (BW'(heap_end_ff) > HEAP_BYTES) ? HEAP_BYTES : BW'(heap_end_ff);
      end_b       = end_clamp & ALIGN_MASK;
      too_small   = (start_b + SETUP_MIN) > end_b;
      setup_first = start_b[IW+2:3];
      setup_last  = end_b[IW+2:3] - IW'(1);
   end

   // ---- request decode
   logic [BW-1:0] req_want;
   logic [BW-1:0] rel_blk;
   logic          free_bad;
   always_comb begin
      req_want = (BW'(req_ch.request_bytes) + BW'(7)) & ALIGN_MASK;
      rel_blk  = BW'(req_ch.release_address >> 3) - BW'(1);
      free_bad = !heap_ready_ff || (req_ch.release_address < USER_ADDR_W'(8)) ||
                 (rel_blk >= BW'(HEAP_WORDS));
   end

   // ---- search step, merge stop, fit test
   logic [IW-1:0] adv_src;
   logic          adv_wrap;
   logic          merge_stop;
   logic [BW-1:0] size_b, rem_b, split_b, uaddr_b;
   logic          fit, rem_small;
   always_comb begin
      adv_src    = (state_ff == ST_CHECK_CUR) ? rd_next : cur_next_ff;
      adv_wrap   = (adv_src == start_ff) || (step_ff == HW_CNT);
      merge_stop = (merge_ff == HW_CNT) || (nb_ff == first_ff);
      size_b     = (BW'(cur_next_ff) - BW'(cur_ff) - BW'(1)) << 3;
      fit        = (cur_next_ff > cur_ff) && (size_b >= want_ff);
      rem_b      = size_b - want_ff;
      rem_small  = rem_b < SPLIT_MIN;
      split_b    = BW'(cur_ff) + BW'(1) + (want_ff >> 3);
      uaddr_b    = (BW'(cur_ff) + BW'(1)) << 3;
   end

   // ---- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_WORD) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.command == CMD_ALLOC) begin
                  if (heap_ready_ff)   state_in = ST_READ_CUR;
                  else if (!too_small) state_in = ST_SETUP_LAST;
               end else if (!free_bad) begin
                  state_in = ST_FREE_READ;
               end
            end
         end
         ST_SETUP_LAST: state_in = ST_READ_CUR;
         ST_READ_CUR:   state_in = ST_CHECK_CUR;
         ST_CHECK_CUR: begin
            if (rd_free)       state_in = ST_MERGE_READ;
            else if (adv_wrap) state_in = ST_IDLE;
            else               state_in = ST_READ_CUR;
         end
         ST_MERGE_READ: begin
            if (!merge_stop)           state_in = ST_MERGE_CHECK;
            else if (cmd_ff == CMD_FREE) state_in = ST_IDLE;
            else                       state_in = ST_EVAL;
         end
         ST_MERGE_CHECK: begin
            if (rd_free)                 state_in = ST_MERGE_READ;
            else if (cmd_ff == CMD_FREE) state_in = ST_IDLE;
            else                         state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (fit)           state_in = rem_small ? ST_IDLE : ST_SPLIT_HEAD;
            else if (adv_wrap) state_in = ST_IDLE;
            else               state_in = ST_READ_CUR;
         end
         ST_SPLIT_HEAD: state_in = ST_IDLE;
         ST_FREE_READ:  state_in = ST_FREE_CHECK;
         ST_FREE_CHECK: state_in = rd_free ? ST_IDLE : ST_MERGE_READ;
         default:       state_in = ST_IDLE;
      endcase
   end

   // ---- datapath, memory port and response
   always_comb begin
      cmd_in        = cmd_ff;
      want_in       = want_ff;
      cur_in        = cur_ff;
      cur_next_in   = cur_next_ff;
      nb_in         = nb_ff;
      start_in      = start_ff;
      rover_in      = rover_ff;
      first_in      = first_ff;
      split_in      = split_ff;
      clr_in        = clr_ff;
      step_in       = step_ff;
      merge_in      = merge_ff;
      heap_ready_in = heap_ready_ff;
      mem_we        = 1'b0;
      mem_addr      = cur_ff;
      mem_wnext     = cur_next_ff;
      mem_wfree     = 1'b0;
      done          = 1'b0;
      done_addr     = '0;
      done_status   = STAT_NO_SPACE;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_ff;
            mem_wnext = '0;
            clr_in    = clr_ff + IW'(1);
         end
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in  = req_ch.command;
               want_in = req_want;
               if (req_ch.command == CMD_ALLOC) begin
                  if (heap_ready_ff) begin
                     cur_in   = rover_ff;
                     start_in = rover_ff;
                     step_in  = '0;
                  end else if (too_small) begin
                     done        = 1'b1;
                     done_status = STAT_NO_SPACE;
                  end else begin
                     // first header spans the region, end header comes next
                     mem_we      = 1'b1;
                     mem_addr    = setup_first;
                     mem_wnext   = setup_last;
                     mem_wfree   = 1'b1;
                     first_in    = setup_first;
                     cur_next_in = setup_last;
                  end
               end else if (free_bad) begin
                  done        = 1'b1;
                  done_status = STAT_IGNORED;
               end else begin
                  cur_in = rel_blk[IW-1:0];
               end
            end
         end
         ST_SETUP_LAST: begin
            mem_we        = 1'b1;
            mem_addr      = cur_next_ff;
            mem_wnext     = first_ff;
            mem_wfree     = 1'b0;
            rover_in      = first_ff;
            heap_ready_in = 1'b1;
            cur_in        = first_ff;
            start_in      = first_ff;
            step_in       = '0;
         end
         ST_READ_CUR: begin
            mem_addr = cur_ff;
         end
         ST_CHECK_CUR: begin
            cur_next_in = rd_next;
            if (rd_free) begin
               nb_in    = rd_next;
               merge_in = '0;
            end else begin
               cur_in  = rd_next;
               step_in = step_ff + CW'(1);
               if (adv_wrap) begin
                  rover_in    = start_ff;
                  done        = 1'b1;
                  done_status = STAT_NO_SPACE;
               end
            end
         end
         ST_MERGE_READ: begin
            mem_addr = nb_ff;
            if (merge_stop && cmd_ff == CMD_FREE) begin
               done        = 1'b1;
               done_status = STAT_FREED;
            end
         end
         ST_MERGE_CHECK: begin
            if (rd_free) begin
               // absorb the following free block
               mem_we      = 1'b1;
               mem_addr    = cur_ff;
               mem_wnext   = rd_next;
               mem_wfree   = 1'b1;
               cur_next_in = rd_next;
               nb_in       = rd_next;
               merge_in    = merge_ff + CW'(1);
            end else if (cmd_ff == CMD_FREE) begin
               done        = 1'b1;
               done_status = STAT_FREED;
            end
         end
         ST_EVAL: begin
            if (fit) begin
               if (rem_small) begin
                  mem_we      = 1'b1;
                  mem_addr    = cur_ff;
                  mem_wnext   = cur_next_ff;
                  mem_wfree   = 1'b0;
                  rover_in    = cur_next_ff;
                  done        = 1'b1;
                  done_addr   = uaddr_b[USER_ADDR_W-1:0];
                  done_status = STAT_ALLOCATED;
               end else begin
                  // remainder header first, then shrink the taken block
                  mem_we    = 1'b1;
                  mem_addr  = split_b[IW-1:0];
                  mem_wnext = cur_next_ff;
                  mem_wfree = 1'b1;
                  split_in  = split_b[IW-1:0];
               end
            end else begin
               cur_in  = cur_next_ff;
               step_in = step_ff + CW'(1);
               if (adv_wrap) begin
                  rover_in    = start_ff;
                  done        = 1'b1;
                  done_status = STAT_NO_SPACE;
               end
            end
         end
         ST_SPLIT_HEAD: begin
            mem_we      = 1'b1;
            mem_addr    = cur_ff;
            mem_wnext   = split_ff;
            mem_wfree   = 1'b0;
            rover_in    = split_ff;
            done        = 1'b1;
            done_addr   = uaddr_b[USER_ADDR_W-1:0];
            done_status = STAT_ALLOCATED;
         end
         ST_FREE_READ: begin
            mem_addr = cur_ff;
         end
         ST_FREE_CHECK: begin
            if (rd_free) begin
               done        = 1'b1;
               done_status = STAT_IGNORED;
            end else begin
               mem_we      = 1'b1;
               mem_addr    = cur_ff;
               mem_wnext   = rd_next;
               mem_wfree   = 1'b1;
               cur_next_in = rd_next;
               nb_in       = rd_next;
               merge_in    = '0;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // ---- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         heap_start_ff <= '0;
         heap_end_ff   <= HEAP_END_W'(32768);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HEAP_START: heap_start_ff <= csr_write_data[HEAP_START_W-1:0];
            CSR_HEAP_END:   heap_end_ff   <= csr_write_data[HEAP_END_W-1:0];
            default:        heap_end_ff   <= heap_end_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         rover_ff      <= '0;
         first_ff      <= '0;
         heap_ready_ff <= 1'b0;
         step_ff       <= '0;
         merge_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rover_ff      <= rover_in;
         first_ff      <= first_in;
         heap_ready_ff <= heap_ready_in;
         step_ff       <= step_in;
         merge_ff      <= merge_in;
         if (done)              rsp_valid_ff <= 1'b1;
         else if (rsp_ch.ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      want_ff     <= want_in;
      cur_ff      <= cur_in;
      cur_next_ff <= cur_next_in;
      nb_ff       <= nb_in;
      start_ff    <= start_in;
      split_ff    <= split_in;
      if (done) begin
         rsp_addr_ff   <= done_addr;
         rsp_status_ff <= done_status;
      end
   end

endmodule

// ===== hw/rtl/nfha_hdr_ram.sv =====
// Header store: one entry per heap word, next index plus free flag.
// Single port, read-first, registered read data.
module nfha_hdr_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] addr,
   input  logic [AW-1:0] wr_next,
   input  logic          wr_free,
   output logic [AW-1:0] rd_next,
   output logic          rd_free
);
   logic [AW:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= {wr_free, wr_next};
      end
      {rd_free, rd_next} <= mem[addr];
   end
endmodule

// ===== bench/tb_top.sv =====
module tb_top;
   import nfha_pkg::*;

   localparam int HW        = 4096;   // header words, matches the block default
   localparam int MINP      = 8;      // smallest payload worth splitting off
   localparam int WDOG_MAX  = 200000; // idle cycles; clearing pass plus worst walk

   typedef struct {
      logic [USER_ADDR_W-1:0] user_address;
      logic [STATUS_W-1:0]    status;
   } alloc_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = CSR_HEAP_START;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;

   nfha_req_if req_ch ();
   nfha_rsp_if rsp_ch ();

   next_fit_heap_allocator i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Heap shadow: our own copy of the header chain, rover and registers
   // ---------------------------------------------------------------------
   int unsigned hdr_link [HW];
   bit          hdr_free [HW];
   int unsigned first_idx;
   int unsigned rover_idx;
   bit          heap_built;
   int unsigned reg_start;
   int unsigned reg_end;

   alloc_result_type pending_results[$]; // expected, oldest first
   logic [15:0]      live_blocks[$];     // user addresses currently allocated
   logic [15:0]      dead_blocks[$];     // recently released, for double frees

   int idle_pct;   // sender gap chance, percent
   int stall_pct;  // receiver stall chance, percent
   int errors;
   int n_checked;
   int n_alloc_ok, n_no_space, n_freed, n_ignored;

   function automatic int unsigned link_of(int unsigned i);
      return (i < HW) ? hdr_link[i] : 0;
   endfunction

   function automatic bit is_free(int unsigned i);
      return (i < HW) ? hdr_free[i] : 1'b0;
   endfunction

   function automatic void set_hdr(int unsigned i, int unsigned lnk, bit fr);
      if (i < HW) begin
         hdr_link[i] = lnk;
         hdr_free[i] = fr;
      end
   endfunction

   // absorb the run of free blocks that follows blk
   function automatic void coalesce(int unsigned blk);
      int unsigned nb;
      nb = link_of(blk);
      for (int g = 0; g < HW; g++) begin
         if (!is_free(nb) || nb == first_idx) break;
         if (blk < HW) hdr_link[blk] = link_of(nb);
         nb = link_of(blk);
      end
   endfunction

   // lazy heap construction on the first allocate
   function automatic void build_heap();
      int unsigned s, e, last;
      s = (reg_start + 7) & ~32'd7;
      e = reg_end;
      if (e > HW * 8) e = HW * 8;
      e = e & ~32'd7;
      if (s + 16 + MINP > e) return;
      first_idx = s >> 3;
      last = (e >> 3) - 1;
      set_hdr(first_idx, last, 1'b1);
      set_hdr(last, first_idx, 1'b0);
      rover_idx = first_idx;
      heap_built = 1'b1;
   endfunction

   function automatic alloc_result_type model_alloc(int unsigned req);
      alloc_result_type r;
      int unsigned want, origin, cur, n, size, split;
      r.user_address = '0;
      r.status = STAT_NO_SPACE;
      want = (req + 7) & ~32'd7;
      if (!heap_built) build_heap();
      if (!heap_built) return r;
      origin = rover_idx;
      cur = origin;
      for (int g = 0; g <= HW; g++) begin
         if (is_free(cur)) begin
            coalesce(cur);
            n = link_of(cur);
            size = (n > cur) ? (n - cur - 1) * 8 : 0;
            if (n > cur && size >= want) begin
               if (size - want < 8 + MINP) begin
                  set_hdr(cur, n, 1'b0);
                  rover_idx = n;
               end else begin
                  split = cur + 1 + (want >> 3);
                  set_hdr(split, n, 1'b1);
                  set_hdr(cur, split, 1'b0);
                  rover_idx = split;
               end
               r.user_address = 16'(((cur + 1) * 8) & 32'hFFFF);
               r.status = STAT_ALLOCATED;
               return r;
            end
         end
         cur = link_of(cur);
         if (cur == origin) break;
      end
      rover_idx = origin;
      return r;
   endfunction

   function automatic alloc_result_type model_release(int unsigned addr);
      alloc_result_type r;
      int unsigned blk;
      r.user_address = '0;
      r.status = STAT_IGNORED;
      if (!heap_built || addr < 8) return r;
      blk = (addr >> 3) - 1;
      if (blk >= HW || is_free(blk)) return r;
      hdr_free[blk] = 1'b1;
      coalesce(blk);
      r.status = STAT_FREED;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Driving
   // ---------------------------------------------------------------------

   // hold valid low, then let everything in flight come back
   task automatic drain();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register writes only with nothing in flight
   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      drain();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_HEAP_START) reg_start = 32'(val & 16'h7FFF);
      else reg_end = 32'(val);
   endtask

   // one transaction on req_ch; expectation computed at acceptance
   task automatic send_item(logic cmd, logic [15:0] nbytes, logic [15:0] addr);
      alloc_result_type r;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.command         <= cmd;
      req_ch.request_bytes   <= nbytes;
      req_ch.release_address <= addr;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      if (cmd == CMD_ALLOC) r = model_alloc(32'(nbytes));
      else r = model_release(32'(addr));
      if (r.status == STAT_ALLOCATED) live_blocks.push_back(r.user_address);
      if (r.status == STAT_FREED) begin
         for (int k = 0; k < live_blocks.size(); k++)
            if (live_blocks[k] == (((addr >> 3) << 3))) begin
               live_blocks.delete(k);
               break;
            end
         dead_blocks.push_back(addr);
         if (dead_blocks.size() > 16) void'(dead_blocks.pop_front());
      end
      pending_results.push_back(r);
   endtask

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_ch.ready <= reset ? 1'b0 : ($urandom_range(99) >= stall_pct);
   end

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      alloc_result_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         n_checked++;
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("tb_top: unexpected transaction addr=%0d status=%0d",
                        rsp_ch.user_address, rsp_ch.status);
         end else begin
            exp_r = pending_results.pop_front();
            case (exp_r.status)
               STAT_ALLOCATED: n_alloc_ok++;
               STAT_NO_SPACE:  n_no_space++;
               STAT_FREED:     n_freed++;
               default:        n_ignored++;
            endcase
            if (rsp_ch.user_address !== exp_r.user_address ||
                rsp_ch.status !== exp_r.status) begin
               errors++;
               if (errors <= 10)
                  $display("tb_top: mismatch #%0d exp addr=%0d status=%0d, got addr=%0d status=%0d",
                           n_checked, exp_r.user_address, exp_r.status,
                           rsp_ch.user_address, rsp_ch.status);
            end
         end
      end
   end

   // watchdog: counts cycles with no transaction on either channel
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WDOG_MAX) begin
         $display("tb_top: watchdog expired, %0d still pending", pending_results.size());
         $display("tb_top: done, errors");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // regions that cannot hold a block: allocate fails, nothing gets built
   task automatic test_unbuildable();
      send_item(CMD_FREE, 16'd0, 16'd8);            // free before setup
      write_reg(CSR_HEAP_START, 16'h7FFF);          // rounds up past the end
      write_reg(CSR_HEAP_END, 16'd0);
      send_item(CMD_ALLOC, 16'd8, 16'd0);
      write_reg(CSR_HEAP_START, 16'd0);
      write_reg(CSR_HEAP_END, 16'd16);              // one short of minimum
      send_item(CMD_ALLOC, 16'd0, 16'd0);
      write_reg(CSR_HEAP_START, 16'd32760);
      write_reg(CSR_HEAP_END, 16'hFFFF);            // clamped to memory size
      send_item(CMD_ALLOC, 16'hFFFF, 16'd0);
      drain();
   endtask

   // real region, then register writes that must not disturb it
   task automatic test_directed();
      logic [15:0] a;
      write_reg(CSR_HEAP_START, 16'd1);             // rounds up to 8
      write_reg(CSR_HEAP_END, 16'd16387);           // rounds down to 16384
      send_item(CMD_ALLOC, 16'd0, 16'd0);           // builds the heap
      drain();
      write_reg(CSR_HEAP_START, 16'd0);             // ignored once built
      write_reg(CSR_HEAP_END, 16'd32768);
      send_item(CMD_ALLOC, 16'd1, 16'd0);
      send_item(CMD_ALLOC, 16'd8, 16'd0);
      send_item(CMD_ALLOC, 16'd9, 16'd0);
      send_item(CMD_ALLOC, 16'd16, 16'd0);
      send_item(CMD_ALLOC, 16'hFFFF, 16'd0);        // never fits
      send_item(CMD_ALLOC, 16'd32768, 16'd0);
      send_item(CMD_FREE, 16'hFFFF, 16'd0);         // null
      send_item(CMD_FREE, 16'd0, 16'd4);            // below first word
      send_item(CMD_FREE, 16'd0, 16'hFFFF);         // beyond memory
      send_item(CMD_FREE, 16'd0, 16'd32776);
      drain();
      a = live_blocks[1];
      send_item(CMD_FREE, 16'd0, a);
      send_item(CMD_FREE, 16'd0, a);                // already free
      send_item(CMD_FREE, 16'd0, live_blocks[1] | 16'd5); // low bits dropped
      send_item(CMD_ALLOC, 16'd16000, 16'd0);       // takes most of the tail
      send_item(CMD_ALLOC, 16'd300, 16'd0);         // wraps past the rover
      drain();
   endtask

   task automatic test_random(int n_items, int gap, int stall);
      int pick;
      logic [15:0] sz, ad;
      idle_pct  = gap;
      stall_pct = stall;
      for (int k = 0; k < n_items; k++) begin
         pick = $urandom_range(99);
         if (pick < 55 || live_blocks.size() == 0) begin
            pick = $urandom_range(99);
            if (pick < 70)      sz = 16'($urandom_range(0, 128));
            else if (pick < 95) sz = 16'($urandom_range(0, 2000));
            else                sz = 16'($urandom);
            send_item(CMD_ALLOC, sz, 16'($urandom));
         end else if (pick < 94) begin
            ad = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
            send_item(CMD_FREE, 16'($urandom), ad);
         end else begin
            // malformed releases: null, tiny, past memory, stale
            pick = $urandom_range(3);
            if (pick == 0)      ad = 16'($urandom_range(0, 7));
            else if (pick == 1) ad = 16'($urandom_range(32776, 65535));
            else if (dead_blocks.size() != 0)
               ad = dead_blocks[$urandom_range(0, dead_blocks.size() - 1)];
            else                ad = 16'd0;
            send_item(CMD_FREE, 16'($urandom), ad);
         end
      end
      drain();
   endtask

   initial begin
      for (int i = 0; i < HW; i++) begin
         hdr_link[i] = 0;
         hdr_free[i] = 1'b0;
      end
      first_idx = 0; rover_idx = 0; heap_built = 1'b0;
      reg_start = 0; reg_end = 32768;
      idle_pct = 0; stall_pct = 0; errors = 0; n_checked = 0;
      n_alloc_ok = 0; n_no_space = 0; n_freed = 0; n_ignored = 0;
      req_ch.valid           = 1'b0;
      req_ch.command         = CMD_ALLOC;
      req_ch.request_bytes   = '0;
      req_ch.release_address = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_unbuildable();
      test_directed();
      test_random(250, 0, 0);
      test_random(250, 47, 0);
      test_random(250, 0, 47);
      test_random(250, 6, 6);

      repeat (20) @(posedge clock);
      $display("tb_top: %0d transactions checked: %0d allocated, %0d no space,",
               n_checked, n_alloc_ok, n_no_space);
      $display("tb_top: %0d freed, %0d ignored releases, %0d mismatches",
               n_freed, n_ignored, errors);
      if (errors == 0 && pending_results.size() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
